>>> rtl/core/mpq_pkg.sv
package mpq_pkg;

    localparam int DEF_CAPACITY = 64;
    localparam int DATA_W       = 32;
    localparam int COUNT_W      = 7;

    typedef enum logic {
        KIND_INSERT = 1'b0,
        KIND_REMOVE = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // One result word as it leaves the sift controller.
    typedef struct packed {
        t_status                  status;
        logic signed [DATA_W-1:0] removed_value;
        logic signed [DATA_W-1:0] top_value;
        logic [COUNT_W-1:0]       count;
    } t_result;

endpackage

>>> rtl/core/mpq_in_if.sv
interface mpq_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 kind;
    logic signed [mpq_pkg::DATA_W-1:0]    value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

>>> rtl/core/mpq_out_if.sv
interface mpq_out_if;
    logic                                 valid;
    logic                                 ready;
    logic [1:0]                           status;
    logic signed [mpq_pkg::DATA_W-1:0]    removed_value;
    logic signed [mpq_pkg::DATA_W-1:0]    top_value;
    logic [mpq_pkg::COUNT_W-1:0]          count;

    modport source (output valid, output status, output removed_value, output top_value,
                    output count, input ready);
    modport sink   (input valid, input status, input removed_value, input top_value,
                    input count, output ready);
endinterface

>>> rtl/core/mpq_store.sv
module mpq_store #(
    parameter int DEPTH  = mpq_pkg::DEF_CAPACITY,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                              i_clk,
    input  logic                              i_we,
    input  logic [ADDR_W-1:0]                 i_waddr,
    input  logic signed [mpq_pkg::DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0]                 i_raddr0,
    input  logic [ADDR_W-1:0]                 i_raddr1,
    output logic signed [mpq_pkg::DATA_W-1:0] o_rdata0,
    output logic signed [mpq_pkg::DATA_W-1:0] o_rdata1
);

    // One write port and two registered read ports.
    logic signed [mpq_pkg::DATA_W-1:0] r_mem [DEPTH];
    logic signed [mpq_pkg::DATA_W-1:0] r_rdata0;
    logic signed [mpq_pkg::DATA_W-1:0] r_rdata1;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata0 <= r_mem[i_raddr0];
        r_rdata1 <= r_mem[i_raddr1];
    end

    assign o_rdata0 = r_rdata0;
    assign o_rdata1 = r_rdata1;

endmodule

>>> rtl/core/mpq_ctrl.sv
module mpq_ctrl #(
    parameter int CAPACITY = mpq_pkg::DEF_CAPACITY,
    localparam int ADDR_W  = $clog2(CAPACITY)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  mpq_pkg::t_kind                    i_kind,
    input  logic signed [mpq_pkg::DATA_W-1:0] i_value,
    output logic                              o_res_valid,
    input  logic                              i_res_ready,
    output mpq_pkg::t_result                  o_result,
    output logic                              o_we,
    output logic [ADDR_W-1:0]                 o_waddr,
    output logic signed [mpq_pkg::DATA_W-1:0] o_wdata,
    output logic [ADDR_W-1:0]                 o_raddr0,
    output logic [ADDR_W-1:0]                 o_raddr1,
    input  logic signed [mpq_pkg::DATA_W-1:0] i_rdata0,
    input  logic signed [mpq_pkg::DATA_W-1:0] i_rdata1
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(2 * CAPACITY + 2);
    localparam int EXT_W = (CNT_W > mpq_pkg::COUNT_W) ? CNT_W : mpq_pkg::COUNT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP,
        S_LOAD,
        S_DOWN,
        S_DONE
    } t_state;

    t_state                            r_state, n_state;
    logic [CNT_W-1:0]                  r_count, n_count;
    logic signed [mpq_pkg::DATA_W-1:0] r_top, n_top;
    logic signed [mpq_pkg::DATA_W-1:0] r_val, n_val;
    logic [IDX_W-1:0]                  r_idx, n_idx;
    mpq_pkg::t_status                  r_status, n_status;
    logic signed [mpq_pkg::DATA_W-1:0] r_removed, n_removed;

    logic [IDX_W-1:0]                  left_idx;
    logic [IDX_W-1:0]                  right_idx;
    logic [IDX_W-1:0]                  parent_idx;
    logic [IDX_W-1:0]                  cnt_idx;
    logic [IDX_W-1:0]                  big_idx;
    logic signed [mpq_pkg::DATA_W-1:0] big_val;
    logic                              left_ok;
    logic                              take_right;
    logic [IDX_W-1:0]                  w_idx;
    logic [EXT_W-1:0]                  cnt_ext;

    // Slot numbers are one-based; the store is addressed from zero.
    function automatic logic [ADDR_W-1:0] to_addr(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] d;
        d = idx - IDX_W'(1);
        return d[ADDR_W-1:0];
    endfunction

    assign left_idx   = {r_idx[IDX_W-2:0], 1'b0};
    assign right_idx  = {r_idx[IDX_W-2:0], 1'b1};
    assign parent_idx = r_idx >> 1;
    assign cnt_idx    = IDX_W'(r_count);
    assign left_ok    = (left_idx <= cnt_idx);
    // The left child wins a tie; the right child counts only if it is held.
    assign take_right = (right_idx <= cnt_idx) && (i_rdata1 > i_rdata0);
    assign big_idx    = take_right ? right_idx : left_idx;
    assign big_val    = take_right ? i_rdata1 : i_rdata0;

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_top     = r_top;
        n_val     = r_val;
        n_idx     = r_idx;
        n_status  = r_status;
        n_removed = r_removed;
        o_we      = 1'b0;
        w_idx     = r_idx;
        o_wdata   = r_val;
        o_raddr0  = '0;
        o_raddr1  = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_status  = mpq_pkg::ST_OK;
                    n_removed = '0;
                    n_state   = S_DONE;
                    if (i_kind == mpq_pkg::KIND_INSERT) begin
                        if (r_count == CNT_W'(CAPACITY)) begin
                            n_status = mpq_pkg::ST_FULL;
                        end else begin
                            n_count = r_count + CNT_W'(1);
                            n_val   = i_value;
                            n_idx   = cnt_idx + IDX_W'(1);
                            if (r_count == '0) begin
                                o_we    = 1'b1;
                                w_idx   = IDX_W'(1);
                                o_wdata = i_value;
                                n_top   = i_value;
                            end else begin
                                o_raddr0 = to_addr(n_idx >> 1);
                                n_state  = S_UP;
                            end
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = mpq_pkg::ST_EMPTY;
                        end else begin
                            n_removed = r_top;
                            n_count   = r_count - CNT_W'(1);
                            if (r_count != CNT_W'(1)) begin
                                o_raddr0 = to_addr(cnt_idx);
                                n_idx    = IDX_W'(1);
                                n_state  = S_LOAD;
                            end
                        end
                    end
                end
            end
            S_UP: begin
                if (r_idx == IDX_W'(1)) begin
                    o_we    = 1'b1;
                    o_wdata = r_val;
                    n_top   = r_val;
                    n_state = S_DONE;
                end else if (i_rdata0 < r_val) begin
                    // Parent moves down into the hole; keep climbing.
                    o_we     = 1'b1;
                    o_wdata  = i_rdata0;
                    n_idx    = parent_idx;
                    o_raddr0 = to_addr(parent_idx >> 1);
                end else begin
                    o_we    = 1'b1;
                    o_wdata = r_val;
                    n_state = S_DONE;
                end
            end
            S_LOAD: begin
                // The last entry arrives; fetch both children of the root.
                n_val    = i_rdata0;
                o_raddr0 = to_addr(left_idx);
                o_raddr1 = to_addr(right_idx);
                n_state  = S_DOWN;
            end
            S_DOWN: begin
                if (left_ok && (r_val < big_val)) begin
                    o_we     = 1'b1;
                    o_wdata  = big_val;
                    n_idx    = big_idx;
                    o_raddr0 = to_addr({big_idx[IDX_W-2:0], 1'b0});
                    o_raddr1 = to_addr({big_idx[IDX_W-2:0], 1'b1});
                    if (r_idx == IDX_W'(1)) begin
                        n_top = big_val;
                    end
                end else begin
                    o_we    = 1'b1;
                    o_wdata = r_val;
                    n_state = S_DONE;
                    if (r_idx == IDX_W'(1)) begin
                        n_top = r_val;
                    end
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_waddr = to_addr(w_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_top     <= n_top;
        r_val     <= n_val;
        r_idx     <= n_idx;
        r_status  <= n_status;
        r_removed <= n_removed;
    end

    assign cnt_ext                = EXT_W'(r_count);
    assign o_in_ready             = (r_state == S_IDLE);
    assign o_res_valid            = (r_state == S_DONE);
    assign o_result.status        = r_status;
    assign o_result.removed_value = r_removed;
    assign o_result.top_value     = (r_count != '0) ? r_top : '0;
    assign o_result.count         = cnt_ext[mpq_pkg::COUNT_W-1:0];

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_we |-> (w_idx != '0) && (w_idx <= IDX_W'(n_count)))
        else $error("store write outside the held entries");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |=> (r_count == $past(r_count)))
        else $error("entry count changed during a sift");

    a_empty_remove: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) && i_in_valid && (i_kind == mpq_pkg::KIND_REMOVE)
        && (r_count == '0)
        |=> (r_state == S_DONE) && (r_status == mpq_pkg::ST_EMPTY) && (r_count == '0))
        else $error("remove from an empty heap not refused");

endmodule

>>> rtl/core/max_heap_priority_queue_core.sv
// Binary max-heap priority queue of signed 32-bit values.
// Requests arrive on i_req: kind 0 inserts value, kind 1 removes the maximum.
// Every accepted request yields exactly one response word on o_rsp carrying
// the status (ok, full, empty), the removed maximum (zero unless a remove
// succeeded), the new maximum (zero when empty) and the new entry count.
// The heap lives in a one-write, two-read synchronous store; the sift walks
// one tree level per cycle, reading the parent or both children while it
// writes the entry it moved. Refused requests and the removal of the only
// entry need no sift and go straight to the response.
// One request is in work at a time: i_req.ready is high whenever the sift
// controller is idle, including while a finished response waits in the
// output register for o_rsp.ready. If the receiver stalls, that register
// holds the response and the controller parks the following one until the
// register frees. Reset empties the queue at once; the store contents need
// no clearing because only values in slots up to the count are ever used.
module max_heap_priority_queue_core #(
    parameter int CAPACITY = mpq_pkg::DEF_CAPACITY
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mpq_in_if.sink    i_req,
    mpq_out_if.source o_rsp
);

    localparam int ADDR_W = $clog2(CAPACITY);

    logic                              res_valid;
    logic                              res_ready;
    mpq_pkg::t_result                  res;
    logic                              we;
    logic [ADDR_W-1:0]                 waddr;
    logic signed [mpq_pkg::DATA_W-1:0] wdata;
    logic [ADDR_W-1:0]                 raddr0;
    logic [ADDR_W-1:0]                 raddr1;
    logic signed [mpq_pkg::DATA_W-1:0] rdata0;
    logic signed [mpq_pkg::DATA_W-1:0] rdata1;

    logic                              r_out_valid;
    mpq_pkg::t_result                  r_out;

    // Sift controller: owns the entry count and the cached root value.
    mpq_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .i_kind      (mpq_pkg::t_kind'(i_req.kind)),
        .i_value     (i_req.value),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_result    (res),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_raddr0    (raddr0),
        .o_raddr1    (raddr1),
        .i_rdata0    (rdata0),
        .i_rdata1    (rdata1)
    );

    // Heap array, slot n at address n-1.
    mpq_store #(
        .DEPTH  (CAPACITY),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk    (i_clk),
        .i_we     (we),
        .i_waddr  (waddr),
        .i_wdata  (wdata),
        .i_raddr0 (raddr0),
        .i_raddr1 (raddr1),
        .o_rdata0 (rdata0),
        .o_rdata1 (rdata1)
    );

    // Output register: it takes a new response whenever it is empty or
    // its current word is being taken in the same cycle.
    assign res_ready = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_out.status;
    assign o_rsp.removed_value = r_out.removed_value;
    assign o_rsp.top_value     = r_out.top_value;
    assign o_rsp.count         = r_out.count;

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int CAP        = mpq_pkg::DEF_CAPACITY;
    localparam int STALL_MAX  = 2000;
    localparam int DRAIN_WAIT = 12;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mpq_in_if  req_if ();
    mpq_out_if rsp_if ();

    max_heap_priority_queue_core #(
        .CAPACITY(CAP)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always #2 i_clk = ~i_clk;

    // Shadow copy of the heap, one-based like the block's slot numbers.
    logic signed [mpq_pkg::DATA_W-1:0] heap_shadow [1:CAP];
    int                                heap_fill = 0;

    mpq_pkg::t_result responses_due[$];
    int               err_cnt    = 0;
    bit               quiet_mode = 1'b0;
    int               stall_cnt  = 0;

    // Applies one request to the shadow heap and returns the response it must produce.
    function automatic mpq_pkg::t_result heap_apply(
        input mpq_pkg::t_kind kind, input logic signed [mpq_pkg::DATA_W-1:0] value);
        mpq_pkg::t_result                  r;
        int                                pos;
        int                                kid;
        logic signed [mpq_pkg::DATA_W-1:0] tmp;
        r.status        = mpq_pkg::ST_OK;
        r.removed_value = '0;
        r.top_value     = '0;
        if (kind == mpq_pkg::KIND_INSERT) begin
            if (heap_fill >= CAP) begin
                r.status = mpq_pkg::ST_FULL;
            end else begin
                heap_fill++;
                heap_shadow[heap_fill] = value;
                pos = heap_fill;
                // Sift up while the parent is strictly smaller.
                while (pos > 1 && heap_shadow[pos / 2] < heap_shadow[pos]) begin
                    tmp                  = heap_shadow[pos / 2];
                    heap_shadow[pos / 2] = heap_shadow[pos];
                    heap_shadow[pos]     = tmp;
                    pos                  = pos / 2;
                end
            end
        end else begin
            if (heap_fill == 0) begin
                r.status = mpq_pkg::ST_EMPTY;
            end else begin
                r.removed_value = heap_shadow[1];
                heap_shadow[1]  = heap_shadow[heap_fill];
                heap_fill--;
                pos = 1;
                // Sift down toward the larger child; the left child wins a tie.
                while (2 * pos <= heap_fill) begin
                    kid = 2 * pos;
                    if (kid + 1 <= heap_fill && heap_shadow[kid + 1] > heap_shadow[kid])
                        kid = kid + 1;
                    if (!(heap_shadow[pos] < heap_shadow[kid]))
                        break;
                    tmp              = heap_shadow[pos];
                    heap_shadow[pos] = heap_shadow[kid];
                    heap_shadow[kid] = tmp;
                    pos              = kid;
                end
            end
        end
        if (heap_fill > 0)
            r.top_value = heap_shadow[1];
        r.count = mpq_pkg::COUNT_W'(heap_fill);
        return r;
    endfunction

    function automatic logic signed [mpq_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(9))
            5, 6, 7: return $signed(32'($urandom_range(16))) - 8;
            8:       return 32'sh7fff_ffff;
            9:       return 32'sh8000_0000;
            default: return $urandom;
        endcase
    endfunction

    // Presents one request word and waits for it to be taken.
    task automatic send_request(input mpq_pkg::t_kind kind,
                                input logic signed [mpq_pkg::DATA_W-1:0] value);
        int gap;
        if (!quiet_mode && $urandom_range(99) < 36) begin
            gap = $urandom_range(1, 3);
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.kind  <= kind;
        req_if.value <= value;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        responses_due.push_back(heap_apply(kind, value));
    endtask

    task automatic test_remove_when_empty();
        send_request(mpq_pkg::KIND_REMOVE, 32'sd0);
        send_request(mpq_pkg::KIND_REMOVE, 32'sh7fff_ffff);
    endtask

    // Field extremes and equal values, then drained past empty.
    task automatic test_extremes_and_ties();
        send_request(mpq_pkg::KIND_INSERT, 32'sh8000_0000);
        send_request(mpq_pkg::KIND_INSERT, 32'sh7fff_ffff);
        send_request(mpq_pkg::KIND_INSERT, 32'sd0);
        send_request(mpq_pkg::KIND_INSERT, -32'sd1);
        send_request(mpq_pkg::KIND_INSERT, 32'sd5);
        send_request(mpq_pkg::KIND_INSERT, 32'sd5);
        send_request(mpq_pkg::KIND_INSERT, 32'sd5);
        send_request(mpq_pkg::KIND_INSERT, 32'sh5555_aaaa);
        repeat (9) send_request(mpq_pkg::KIND_REMOVE, 32'shffff_ffff);
    endtask

    // Fill to capacity, try two more inserts, then empty it and try once more.
    task automatic test_fill_to_capacity();
        repeat (CAP + 2) send_request(mpq_pkg::KIND_INSERT, pick_value());
        repeat (CAP + 1) send_request(mpq_pkg::KIND_REMOVE, pick_value());
    endtask

    // Mixed traffic in blocks that lean toward inserts, toward removes or neither, so the
    // heap swings between empty and full.
    task automatic test_random_mix(input int n_words);
        int lean;
        lean = 50;
        for (int k = 0; k < n_words; k++) begin
            if (k % 40 == 0) begin
                case ($urandom_range(2))
                    0:       lean = 85;
                    1:       lean = 50;
                    default: lean = 15;
                endcase
            end
            if ($urandom_range(99) < lean)
                send_request(mpq_pkg::KIND_INSERT, pick_value());
            else
                send_request(mpq_pkg::KIND_REMOVE, pick_value());
        end
    endtask

    task automatic test_back_to_back();
        quiet_mode = 1'b1;
        test_random_mix(300);
        quiet_mode = 1'b0;
    endtask

    task automatic check_field(input string name, input logic [mpq_pkg::DATA_W-1:0] want,
                               input logic [mpq_pkg::DATA_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected 0x%08h, actual 0x%08h",
                     $time, name, want, got);
            err_cnt++;
        end
    endtask

    always @(posedge i_clk) begin : rsp_check
        mpq_pkg::t_result want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (responses_due.size() == 0) begin
                $display("%0t: unexpected response, expected none, actual status %0d count %0d",
                         $time, rsp_if.status, rsp_if.count);
                err_cnt++;
            end else begin
                want = responses_due.pop_front();
                check_field("status", 32'(want.status), 32'(rsp_if.status));
                check_field("removed_value", want.removed_value, rsp_if.removed_value);
                check_field("top_value", want.top_value, rsp_if.top_value);
                check_field("count", 32'(want.count), 32'(rsp_if.count));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n)
            rsp_if.ready <= 1'b0;
        else if (quiet_mode)
            rsp_if.ready <= 1'b1;
        else
            rsp_if.ready <= ($urandom_range(99) >= 36);
    end

    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= STALL_MAX) begin
            $display("max_heap_priority_queue_core verification failed");
            $finish;
        end
    end

    initial begin
        i_rst_n      <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.kind  <= mpq_pkg::KIND_INSERT;
        req_if.value <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_remove_when_empty();
        test_extremes_and_ties();
        test_fill_to_capacity();
        test_random_mix(600);
        test_back_to_back();
        test_random_mix(600);

        req_if.valid <= 1'b0;
        while (responses_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (err_cnt == 0)
            $display("max_heap_priority_queue_core verification clean");
        else
            $display("max_heap_priority_queue_core verification failed");
        $finish;
    end

endmodule
